[src/lcae_pkg.sv]
`timescale 1ns / 1ps

package lcae_pkg;

	localparam int unsigned LCAE_GRID_DEFAULT = 64;
	localparam int unsigned BIRTH_COUNT       = 3;
	localparam int unsigned SURVIVE_COUNT     = 2;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_STEP  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] row;
		logic [5:0] col;
		logic       value;
	} cmd_t;

	typedef struct packed {
		logic cell_value;
		logic done_res;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET_WR,
		ST_READ,
		ST_STEP_CUR,
		ST_STEP_BELOW,
		ST_STEP_CELL,
		ST_STEP_WR,
		ST_RESP
	} state_t;

endpackage

[src/life_cellular_automaton_engine_unit.sv]
`timescale 1ns / 1ps
// Step: one cell per cycle through a shared neighbor-count unit, plus one row
// fetch and one row write per row. One transaction at a time; a finished
// result waits in the output register. Reset (arst_n low, asynchronous)
// clears the per-row valid bits, so every cell reads dead at once; no clearing
// pass is needed.
module life_cellular_automaton_engine_unit
	import lcae_pkg::*;
#(
	parameter int unsigned GRID = LCAE_GRID_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned AW = $clog2(GRID);

	state_t state_q, state_d;

	logic [GRID-1:0] mem [GRID];
	logic [GRID-1:0] row_valid_q;
	logic [GRID-1:0] rd_data_q;
	logic            rd_valid_q;
	logic [GRID-1:0] rd_row;

	logic            rd_en, wr_en, clr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [GRID-1:0] wr_data;

	cmd_t            cmd_q;
	logic            res_bit_q, res_bit_d;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic            rsp_load;

	logic [GRID-1:0] above_q, cur_q, below_q, new_row_q;
	logic            prev_a_q, prev_c_q, prev_b_q;
	logic [AW-1:0]   row_q, col_q;
	logic [AW:0]     row_plus2;

	logic            cmd_fire, cmd_inside, q_inside;
	logic            last_row, last_col;
	logic            a_n, c_n, b_n;
	logic [3:0]      count;
	logic            new_bit;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd_valid && cmd_ready;
	assign cmd_inside = (int'(cmd.row) < GRID) && (int'(cmd.col) < GRID);
	assign q_inside   = (int'(cmd_q.row) < GRID) && (int'(cmd_q.col) < GRID);
	assign rd_row     = rd_valid_q ? rd_data_q : '0;
	assign last_row   = (row_q == AW'(GRID - 1));
	assign last_col   = (col_q == AW'(GRID - 1));
	assign row_plus2  = {1'b0, row_q} + (AW + 1)'(2);

	assign a_n = above_q[1] && !last_col;
	assign c_n = cur_q[1] && !last_col;
	assign b_n = below_q[1] && !last_col;

	assign count = 4'(prev_a_q) + 4'(above_q[0]) + 4'(a_n) + 4'(prev_c_q)
	             + 4'(c_n) + 4'(prev_b_q) + 4'(below_q[0]) + 4'(b_n);
	assign new_bit = (count == 4'(BIRTH_COUNT))
	              || (cur_q[0] && (count == 4'(SURVIVE_COUNT)));

	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = row_q;
		wr_data   = new_row_q;
		clr_en    = 1'b0;
		res_bit_d = res_bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					res_bit_d = 1'b0;
					unique case (cmd.op)
						OP_SET: begin
							rd_en   = cmd_inside;
							rd_addr = AW'(cmd.row);
							state_d = ST_SET_WR;
						end
						OP_READ: begin
							rd_en   = cmd_inside;
							rd_addr = AW'(cmd.row);
							state_d = ST_READ;
						end
						OP_CLEAR: begin
							clr_en  = 1'b1;
							state_d = ST_RESP;
						end
						OP_STEP: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = ST_STEP_CUR;
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_SET_WR: begin
				wr_en   = q_inside;
				wr_addr = AW'(cmd_q.row);
				wr_data = rd_row;
				wr_data[AW'(cmd_q.col)] = cmd_q.value;
				state_d = ST_RESP;
			end
			ST_READ: begin
				res_bit_d = q_inside && rd_row[AW'(cmd_q.col)];
				state_d   = ST_RESP;
			end
			ST_STEP_CUR: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
				state_d = ST_STEP_BELOW;
			end
			ST_STEP_BELOW: begin
				state_d = ST_STEP_CELL;
			end
			ST_STEP_CELL: begin
				if (last_col) begin
					state_d = ST_STEP_WR;
				end
			end
			ST_STEP_WR: begin
				wr_en = 1'b1;
				if (last_row) begin
					state_d = ST_RESP;
				end else begin
					rd_en   = (int'(row_plus2) < GRID);
					rd_addr = row_plus2[AW-1:0];
					state_d = ST_STEP_BELOW;
				end
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			rsp_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			res_bit_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_bit_q <= res_bit_d;
			if (clr_en) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_STEP_CUR) begin
				row_q <= '0;
			end else if (state_q == ST_STEP_WR && !last_row) begin
				row_q <= row_q + AW'(1);
			end
			if (state_q == ST_STEP_BELOW) begin
				col_q <= '0;
			end else if (state_q == ST_STEP_CELL) begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= row_valid_q[rd_addr];
		end else if (state_q == ST_IDLE) begin
			rd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q <= cmd;
		end
		if (rsp_load) begin
			rsp_q.cell_value <= res_bit_q;
			rsp_q.done_res   <= 1'b1;
		end
		unique case (state_q)
			ST_STEP_CUR: begin
				cur_q   <= rd_row;
				above_q <= '0;
			end
			ST_STEP_BELOW: begin
				below_q  <= last_row ? '0 : rd_row;
				prev_a_q <= 1'b0;
				prev_c_q <= 1'b0;
				prev_b_q <= 1'b0;
			end
			ST_STEP_CELL: begin
				prev_a_q  <= above_q[0];
				prev_c_q  <= cur_q[0];
				prev_b_q  <= below_q[0];
				above_q   <= {above_q[0], above_q[GRID-1:1]};
				cur_q     <= {cur_q[0], cur_q[GRID-1:1]};
				below_q   <= {below_q[0], below_q[GRID-1:1]};
				new_row_q <= {new_bit, new_row_q[GRID-1:1]};
			end
			ST_STEP_WR: begin
				above_q <= cur_q;
				cur_q   <= below_q;
			end
			default: begin
			end
		endcase
	end

	a_wr_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP_WR) |-> ($past(state_q) == ST_STEP_CELL))
		else $error("row write without a finished column sweep");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same row");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd_ready)
		else $error("command taken while another is in flight");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import lcae_pkg::*;

	localparam int GRID_N       = LCAE_GRID_DEFAULT;
	localparam int RANDOM_ITEMS = 116;
	localparam int HOLD_CYCLES  = 6000;
	localparam int HOLD_AFTER   = 40;
	localparam int TAIL_CYCLES  = 30;

	typedef struct {
		cmd_t c;
		bit   fixed;
		logic cv;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic life_grid [GRID_N][GRID_N];
	rsp_t rsp_expected [$];
	dir_row_t dir_tab [$];
	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int burst_left = 0;
	int op_count [4] = '{0, 0, 0, 0};
	bit hold_done  = 1'b0;

	life_cellular_automaton_engine_unit #(
		.GRID(GRID_N)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic cmd_t mk_cmd(op_t op, int unsigned r, int unsigned c, bit v);
		cmd_t x;
		x.op    = op;
		x.row   = 6'(r);
		x.col   = 6'(c);
		x.value = v;
		return x;
	endfunction

	function automatic dir_row_t dir_row(op_t op, int unsigned r, int unsigned c, bit v,
			bit fx, logic cv);
		dir_row_t d;
		d.c     = mk_cmd(op, r, c, v);
		d.fixed = fx;
		d.cv    = cv;
		return d;
	endfunction

	function automatic int unsigned live_at(int r, int c);
		if (r < 0 || c < 0 || r >= GRID_N || c >= GRID_N)
			return 0;
		return life_grid[r][c] ? 1 : 0;
	endfunction

	task automatic clear_life();
		foreach (life_grid[i, j])
			life_grid[i][j] = 1'b0;
	endtask

	task automatic advance_life();
		logic nxt [GRID_N][GRID_N];
		int unsigned n;
		for (int r = 0; r < GRID_N; r++) begin
			for (int c = 0; c < GRID_N; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							n += live_at(r + dr, c + dc);
				nxt[r][c] = (n == BIRTH_COUNT) || (life_grid[r][c] && n == SURVIVE_COUNT);
			end
		end
		life_grid = nxt;
	endtask

	task automatic apply_cmd(input cmd_t c, output rsp_t r);
		bit on_grid;
		on_grid = (int'(c.row) < GRID_N) && (int'(c.col) < GRID_N);
		r = '{cell_value: 1'b0, done_res: 1'b1};
		case (c.op)
			OP_SET: begin
				if (on_grid)
					life_grid[c.row][c.col] = c.value;
			end
			OP_CLEAR: clear_life();
			OP_STEP: advance_life();
			default: begin
				if (on_grid)
					r.cell_value = life_grid[c.row][c.col];
			end
		endcase
	endtask

	task automatic send_cmd(input cmd_t c, input bit fx, input logic cv);
		rsp_t want;
		int unsigned gap;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		apply_cmd(c, want);
		if (fx)
			want = '{cell_value: cv, done_res: 1'b1};
		rsp_expected = {rsp_expected, want};
		op_count[int'(c.op)]++;
		n_accepted++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic int unsigned pick_origin();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return GRID_N - 5;
			default: return $urandom_range(0, GRID_N - 5);
		endcase
	endfunction

	function automatic int unsigned near(int unsigned base);
		int v;
		v = int'(base) + int'($urandom_range(0, 6)) - 1;
		if (v < 0)
			v = 0;
		if (v >= GRID_N)
			v = GRID_N - 1;
		return v;
	endfunction

	// Seed a 5x5 patch, usually step it, then probe around it.
	task automatic run_patch();
		int unsigned r0;
		int unsigned c0;
		r0 = pick_origin();
		c0 = pick_origin();
		if ($urandom_range(0, 2) == 0)
			send_cmd(mk_cmd(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
				1'($urandom_range(0, 1))), 1'b0, 1'b0);
		repeat ($urandom_range(4, 12))
			send_cmd(mk_cmd(OP_SET, r0 + $urandom_range(0, 4), c0 + $urandom_range(0, 4),
				$urandom_range(0, 3) != 0), 1'b0, 1'b0);
		if ($urandom_range(0, 3) != 0)
			send_cmd(mk_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
				1'($urandom_range(0, 1))), 1'b0, 1'b0);
		repeat ($urandom_range(3, 6))
			send_cmd(mk_cmd(OP_READ, near(r0), near(c0), 1'($urandom_range(0, 1))),
				1'b0, 1'b0);
	endtask

	task automatic send_noise();
		op_t op;
		op = op_t'($urandom_range(0, 3));
		if (op == OP_STEP && $urandom_range(0, 1) == 0)
			op = OP_READ;
		send_cmd(mk_cmd(op, $urandom_range(0, 63), $urandom_range(0, 63),
			1'($urandom_range(0, 1))), 1'b0, 1'b0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		clear_life();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_tab = {dir_tab, dir_row(OP_READ,   0,  0, 1'b0, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  63, 63, 1'b1, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,   0, 63, 1'b0, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,    0,  0, 1'b1, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,   0,  0, 1'b0, 1'b1, 1'b1)};
		dir_tab = {dir_tab, dir_row(OP_SET,   63, 63, 1'b1, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  63, 63, 1'b1, 1'b1, 1'b1)};
		dir_tab = {dir_tab, dir_row(OP_SET,   63, 63, 1'b0, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  63, 63, 1'b0, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,    0,  1, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,    1,  0, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_STEP,  63, 63, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,   1,  1, 1'b0, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,   0,  0, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,   63, 30, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,   63, 31, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,   63, 32, 1'b1, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_STEP,   0,  0, 1'b0, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  62, 31, 1'b0, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  63, 30, 1'b0, 1'b0, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_CLEAR, 42, 21, 1'b1, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,   0,  0, 1'b1, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_READ,  62, 31, 1'b0, 1'b1, 1'b0)};
		dir_tab = {dir_tab, dir_row(OP_SET,    0,  0, 1'b0, 1'b1, 1'b0)};

		foreach (dir_tab[i])
			send_cmd(dir_tab[i].c, dir_tab[i].fixed, dir_tab[i].cv);

		while (n_accepted < dir_tab.size() + RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				run_patch();
		end
		cmd_valid <= 1'b0;

		wait (rsp_expected.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (rsp_expected.size() != 0) begin
			$display("%0t: %0d responses still outstanding", $time, rsp_expected.size());
			n_errors++;
		end

		$display("run covered %0d transactions (set %0d, clear %0d, step %0d, read %0d)",
			n_accepted, op_count[OP_SET], op_count[OP_CLEAR], op_count[OP_STEP],
			op_count[OP_READ]);
		$display("%0d responses checked, %0d-cycle response hold-off under input back-pressure",
			n_checked, HOLD_CYCLES);
		if (n_errors == 0)
			$display("** life_cellular_automaton_engine_unit: PASSED **");
		else
			$display("** life_cellular_automaton_engine_unit: FAILED **");
		$finish;
	end

	initial begin
		int unsigned mode;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && n_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(4, 40)) begin
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : chk_rsp
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expected.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual cell_value=%0b done_res=%0b",
					$time, rsp.cell_value, rsp.done_res);
				n_errors++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp.cell_value !== want.cell_value) begin
					$display("%0t: cell_value mismatch, expected %0b, actual %0b",
						$time, want.cell_value, rsp.cell_value);
					n_errors++;
				end
				if (rsp.done_res !== want.done_res) begin
					$display("%0t: done_res mismatch, expected %0b, actual %0b",
						$time, want.done_res, rsp.done_res);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	initial begin
		#40ms;
		$display("%0t: timeout with %0d responses outstanding", $time, rsp_expected.size());
		$display("** life_cellular_automaton_engine_unit: FAILED **");
		$finish;
	end

endmodule

[life_cellular_automaton_engine_unit.f]
src/lcae_pkg.sv
src/life_cellular_automaton_engine_unit.sv
tb/sv/tb.sv
